// ===== rtl/mpid_pkg.sv =====
// Package for the multichannel PID controller: shared types, codes and constants.
// Used by every module in rtl/; depends on nothing.
package mpid_pkg;

    localparam int MaxAgentsDef = 16;
    localparam int MaxDimsDef   = 4;
    localparam int AgentW       = 4;
    localparam int DimW         = 2;
    localparam int DataW        = 32;
    localparam int IntegW       = 48;
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 28;
    localparam int TsW          = 24;
    localparam int InvTsW       = 28;
    localparam int CoefW        = 17;
    localparam int KindW        = 3;

    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_TIME = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_INV_TS      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FILTER      = 2'd2;

    localparam logic [KindW-1:0] KIND_KP    = 3'd0;
    localparam logic [KindW-1:0] KIND_KI    = 3'd1;
    localparam logic [KindW-1:0] KIND_KD    = 3'd2;
    localparam logic [KindW-1:0] KIND_LOWER = 3'd3;
    localparam logic [KindW-1:0] KIND_UPPER = 3'd4;

    localparam logic [CoefW-1:0] COEF_ONE = 17'd65536;

    // One queued sample request from the front end to the datapath.
    typedef struct packed {
        logic [AgentW-1:0]       agent;
        logic [DimW-1:0]         dim;
        logic signed [DataW-1:0] err;
    } t_job;

    // Saturate a signed 80-bit value to 32 bits.
    function automatic logic signed [DataW-1:0] sat32(input logic signed [79:0] v);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        hi = 80'sh7FFF_FFFF;
        lo = -80'sh8000_0000;
        if (v > hi)      sat32 = 32'sh7FFF_FFFF;
        else if (v < lo) sat32 = 32'sh8000_0000;
        else             sat32 = v[DataW-1:0];
    endfunction

endpackage

// ===== rtl/mpid_front.sv =====
// Front end of the PID controller: decodes requests, keeps the gain and
// limit tables, and queues sample jobs. Depends on mpid_pkg.
module mpid_front #(
    parameter int MAX_AGENTS = mpid_pkg::MaxAgentsDef,
    parameter int MAX_DIMS   = mpid_pkg::MaxDimsDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [mpid_pkg::AgentW-1:0]     i_agent_index,
    input  logic [mpid_pkg::DimW-1:0]       i_dimension_index,
    input  logic signed [31:0]              i_error_value,
    input  logic [mpid_pkg::KindW-1:0]      i_coef_kind,
    input  logic signed [31:0]              i_coef_value,
    output logic                            o_job_valid,
    input  logic                            i_job_take,
    input  logic                            i_back_busy,
    output mpid_pkg::t_job                  o_job,
    output logic signed [31:0]              o_kp [mpid_pkg::MaxDimsDef],
    output logic signed [31:0]              o_ki [mpid_pkg::MaxDimsDef],
    output logic signed [31:0]              o_kd [mpid_pkg::MaxDimsDef],
    output logic signed [31:0]              o_lo [mpid_pkg::MaxDimsDef],
    output logic signed [31:0]              o_hi [mpid_pkg::MaxDimsDef]
);
    import mpid_pkg::*;

    // Two-entry job queue.
    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_acc;
    logic       w_push;
    logic       w_pop;
    logic       w_in_range;

    // A coefficient write waits until every earlier sample has used the tables.
    assign o_stall    = (r_cnt == 2'd2) ||
                        (i_operation && ((r_cnt != 2'd0) || i_back_busy));
    assign w_acc      = i_valid && !o_stall;
    assign w_in_range = (32'(i_agent_index) < 32'(MAX_AGENTS)) &&
                        (32'(i_dimension_index) < 32'(MAX_DIMS));
    assign w_push     = w_acc && !i_operation && w_in_range;
    assign w_pop      = i_job_take && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{agent: i_agent_index, dim: i_dimension_index,
                           err: i_error_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MaxDimsDef; k++) begin
                o_kp[k] <= '0;
                o_ki[k] <= '0;
                o_kd[k] <= '0;
                o_lo[k] <= 32'sh8000_0000;
                o_hi[k] <= 32'sh7FFF_FFFF;
            end
        end else if (w_acc && i_operation &&
                     32'(i_dimension_index) < 32'(MAX_DIMS)) begin
            case (i_coef_kind)
                KIND_KP:    o_kp[i_dimension_index] <= i_coef_value;
                KIND_KI:    o_ki[i_dimension_index] <= i_coef_value;
                KIND_KD:    o_kd[i_dimension_index] <= i_coef_value;
                KIND_LOWER: o_lo[i_dimension_index] <= i_coef_value;
                KIND_UPPER: o_hi[i_dimension_index] <= i_coef_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (r_cnt != 2'd3) else $error("queue count overflow");
        end
    end
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not advance");
endmodule

// ===== rtl/mpid_back.sv =====
// Datapath of the PID controller: per-channel state memories and a sequenced
// arithmetic pass per sample with one shared multiplier. Depends on mpid_pkg.
module mpid_back #(
    parameter int MAX_AGENTS = mpid_pkg::MaxAgentsDef,
    parameter int MAX_DIMS   = mpid_pkg::MaxDimsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    output logic                         o_job_take,
    output logic                         o_busy,
    input  mpid_pkg::t_job               i_job,
    input  logic [mpid_pkg::TsW-1:0]     i_ts,
    input  logic [mpid_pkg::InvTsW-1:0]  i_inv_ts,
    input  logic [mpid_pkg::CoefW-1:0]   i_filt,
    input  logic signed [31:0]           i_kp [mpid_pkg::MaxDimsDef],
    input  logic signed [31:0]           i_ki [mpid_pkg::MaxDimsDef],
    input  logic signed [31:0]           i_kd [mpid_pkg::MaxDimsDef],
    input  logic signed [31:0]           i_lo [mpid_pkg::MaxDimsDef],
    input  logic signed [31:0]           i_hi [mpid_pkg::MaxDimsDef],
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [31:0]           o_control_value,
    output logic [mpid_pkg::AgentW-1:0]  o_out_agent,
    output logic [mpid_pkg::DimW-1:0]    o_out_dimension,
    output logic                         o_clamped
);
    import mpid_pkg::*;

    localparam int NCh  = MAX_AGENTS * MAX_DIMS;
    localparam int ChW  = (NCh > 1) ? $clog2(NCh) : 1;
    localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_RAWD = 9'b000000100,
        S_FILT = 9'b000001000,
        S_INTG = 9'b000010000,
        S_KP   = 9'b000100000,
        S_KIH  = 9'b001000000,
        S_KIL  = 9'b010000000,
        S_KD   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State memories: one entry per channel; valid bits hold the reset value.
    logic signed [31:0] r_perr_mem [NCh];
    logic signed [31:0] r_dflt_mem [NCh];
    logic signed [47:0] r_intg_mem [NCh];
    logic [NCh-1:0]     r_seen;

    logic signed [31:0] r_perr_rd;
    logic signed [31:0] r_dflt_rd;
    logic signed [47:0] r_intg_rd;
    logic               r_seen_rd;

    logic [ChW-1:0]     r_ch;
    logic [AgentW-1:0]  r_agent;
    logic [DimW-1:0]    r_dim;
    logic signed [31:0] r_e;
    logic signed [31:0] r_rawd;
    logic signed [31:0] r_d;
    logic signed [47:0] r_integ;
    logic signed [65:0] r_y;

    logic [ChW-1:0]     w_ch;
    logic [DW-1:0]      w_di;
    logic signed [32:0] w_p;
    logic signed [79:0] w_prod;
    logic signed [79:0] w_t;
    logic [CoefW-1:0]   w_c;
    logic signed [32:0] w_a;
    logic signed [31:0] w_b;
    logic signed [65:0] w_yf;
    logic signed [65:0] w_hi;
    logic signed [65:0] w_lo;

    assign w_ch = ChW'(32'(i_job.agent) * MAX_DIMS + 32'(i_job.dim));
    assign w_di = DW'(r_dim);
    assign w_p  = r_seen_rd ? 33'(r_perr_rd) : 33'(r_e);
    assign w_c  = (i_filt > COEF_ONE) ? COEF_ONE : i_filt;
    assign o_job_take = (r_state == S_IDLE) && !o_valid;
    assign o_busy     = (r_state != S_IDLE);

    // Shared multiplier operands per step.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_RAWD: begin w_a = 33'(r_e) - w_p; w_b = 32'($signed({1'b0, i_inv_ts})); end
            S_INTG: begin w_a = 33'(r_e) + w_p; w_b = 32'($signed({1'b0, i_ts})); end
            S_KP:   begin w_a = 33'(i_kp[w_di]); w_b = r_e; end
            S_KIH:  begin w_a = 33'(i_ki[w_di]); w_b = 32'(r_integ >>> 16); end
            S_KIL:  begin w_a = 33'(i_ki[w_di]); w_b = 32'($signed({1'b0, r_integ[15:0]})); end
            S_KD:   begin w_a = 33'(i_kd[w_di]); w_b = r_d; end
            default: ;
        endcase
    end
    assign w_prod = 80'(w_a) * 80'(w_b);

    // Filter blend: two narrow products share one step.
    assign w_t = 80'($signed({1'b0, w_c})) * 80'(r_rawd)
               + 80'($signed({1'b0, 17'(COEF_ONE - w_c)})) * 80'(r_dflt_rd)
               + 80'sd32768;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_job_valid && o_job_take) n_state = S_READ;
            S_READ: n_state = S_RAWD;
            S_RAWD: n_state = S_FILT;
            S_FILT: n_state = S_INTG;
            S_INTG: n_state = S_KP;
            S_KP:   n_state = S_KIH;
            S_KIH:  n_state = S_KIL;
            S_KIL:  n_state = S_KD;
            S_KD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic signed [79:0] w_isum;
    assign w_isum = 80'(r_intg_rd) + ((w_prod + 80'sd1048576) >>> 21);
    assign w_yf   = r_y + 66'((w_prod + 80'sd32768) >>> 16);
    assign w_hi   = 66'(i_hi[w_di]);
    assign w_lo   = 66'(i_lo[w_di]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (r_state == S_KD) begin
                o_valid   <= 1'b1;
                r_seen[r_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ch    <= w_ch;
                r_agent <= i_job.agent;
                r_dim   <= i_job.dim;
                r_e     <= i_job.err;
            end
            S_READ: begin
                r_perr_rd <= r_perr_mem[r_ch];
                r_dflt_rd <= r_seen[r_ch] ? r_dflt_mem[r_ch] : 32'sd0;
                r_intg_rd <= r_seen[r_ch] ? r_intg_mem[r_ch] : 48'sd0;
                r_seen_rd <= r_seen[r_ch];
            end
            S_RAWD: r_rawd <= sat32((w_prod + 80'sd2048) >>> 12);
            S_FILT: r_d    <= sat32(w_t >>> 16);
            S_INTG: begin
                if (w_isum > 80'sh7FFF_FFFF_FFFF)       r_integ <= 48'sh7FFF_FFFF_FFFF;
                else if (w_isum < -80'sh8000_0000_0000) r_integ <= 48'sh8000_0000_0000;
                else                                    r_integ <= w_isum[47:0];
                r_y <= '0;
            end
            S_KP:  r_y <= w_yf;
            S_KIH: r_y <= r_y + 66'(w_prod);
            S_KIL: r_y <= w_yf;
            S_KD: begin
                r_perr_mem[r_ch] <= r_e;
                r_dflt_mem[r_ch] <= r_d;
                r_intg_mem[r_ch] <= r_integ;
                o_out_agent      <= r_agent;
                o_out_dimension  <= r_dim;
                if (w_yf > w_hi) begin
                    o_control_value <= i_hi[w_di];
                    o_clamped       <= 1'b1;
                end else if (w_yf < w_lo) begin
                    o_control_value <= i_lo[w_di];
                    o_clamped       <= 1'b1;
                end else begin
                    o_control_value <= w_yf[31:0];
                    o_clamped       <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> (r_state == S_IDLE)) else $error("take outside idle");
    a_result_after_kd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_KD)) else $error("stray result");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
endmodule

// ===== rtl/multichannel_pid_controller_unit.sv =====
// Multichannel PID controller: sample requests wait in a front queue of two while
// the datapath sequencer of eight steps plus idle works on one sample at a time; it
// takes the next sample only after the last result has been handed over, so an
// output stall holds it. The shared multiplier step sequence sets the rate. A
// coefficient write is accepted once the queue and datapath are empty, is
// registered into the tables and gives no result.
// Synchronous active-low reset clears control and channel valid bits, zeroes the gains and opens the limits.
module multichannel_pid_controller_unit #(
    parameter int MAX_AGENTS = mpid_pkg::MaxAgentsDef,
    parameter int MAX_DIMS   = mpid_pkg::MaxDimsDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [mpid_pkg::AgentW-1:0]     i_agent_index,
    input  logic [mpid_pkg::DimW-1:0]       i_dimension_index,
    input  logic signed [31:0]              i_error_value,
    input  logic [mpid_pkg::KindW-1:0]      i_coef_kind,
    input  logic signed [31:0]              i_coef_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [31:0]              o_control_value,
    output logic [mpid_pkg::AgentW-1:0]     o_out_agent,
    output logic [mpid_pkg::DimW-1:0]       o_out_dimension,
    output logic                            o_clamped,
    input  logic                            i_cfg_we,
    input  logic [mpid_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [mpid_pkg::CfgDataW-1:0]   i_cfg_data
);
    import mpid_pkg::*;

    // Configuration registers.
    logic [TsW-1:0]    r_ts;
    logic [InvTsW-1:0] r_inv_ts;
    logic [CoefW-1:0]  r_filt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts     <= 24'd10486;
            r_inv_ts <= 28'd409600;
            r_filt   <= COEF_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_TIME: r_ts     <= i_cfg_data[TsW-1:0];
                CFG_INV_TS:      r_inv_ts <= i_cfg_data[InvTsW-1:0];
                CFG_FILTER:      r_filt   <= i_cfg_data[CoefW-1:0];
                default: ;
            endcase
        end
    end

    // The front end decodes requests and holds the gain and limit tables;
    // sample requests wait in its queue for the datapath. A coefficient write
    // is held off while any earlier sample still needs the tables.
    t_job               w_job;
    logic               w_job_valid;
    logic               w_job_take;
    logic               w_back_busy;
    logic signed [31:0] w_kp [MaxDimsDef];
    logic signed [31:0] w_ki [MaxDimsDef];
    logic signed [31:0] w_kd [MaxDimsDef];
    logic signed [31:0] w_lo [MaxDimsDef];
    logic signed [31:0] w_hi [MaxDimsDef];

    mpid_front #(.MAX_AGENTS(MAX_AGENTS), .MAX_DIMS(MAX_DIMS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation, .i_agent_index,
        .i_dimension_index, .i_error_value, .i_coef_kind, .i_coef_value,
        .o_job_valid(w_job_valid), .i_job_take(w_job_take),
        .i_back_busy(w_back_busy), .o_job(w_job),
        .o_kp(w_kp), .o_ki(w_ki), .o_kd(w_kd), .o_lo(w_lo), .o_hi(w_hi)
    );

    // The datapath walks each sample through derivative, integral and the
    // three gain products, then clamps and registers the result.
    mpid_back #(.MAX_AGENTS(MAX_AGENTS), .MAX_DIMS(MAX_DIMS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_job_valid), .o_job_take(w_job_take),
        .o_busy(w_back_busy),
        .i_job(w_job), .i_ts(r_ts), .i_inv_ts(r_inv_ts), .i_filt(r_filt),
        .i_kp(w_kp), .i_ki(w_ki), .i_kd(w_kd), .i_lo(w_lo), .i_hi(w_hi),
        .o_valid, .i_stall, .o_control_value, .o_out_agent, .o_out_dimension,
        .o_clamped
    );
endmodule
